### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a result in the next.
`define TFD_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (nxt)) \
        else $error(msg);

`endif

### design/tfd_pkg.sv
`default_nettype none

package tfd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OCR_TEXT_CAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TEXT_CAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_CAP      = 3'd4;

    // Register reset values
    localparam logic [31:0] RST_MAGIC_WORD     = 32'h314E_4553;
    localparam logic [11:0] RST_COMMAND_CAP    = 12'd64;
    localparam logic [11:0] RST_OCR_TEXT_CAP   = 12'd255;
    localparam logic [11:0] RST_COLOR_TEXT_CAP = 12'd63;
    localparam logic [15:0] RST_AUDIO_CAP      = 16'd3200;

    // Message types
    localparam logic [7:0] MSG_OCR_RESULT   = 8'd3;
    localparam logic [7:0] MSG_COMMAND      = 8'd4;
    localparam logic [7:0] MSG_TTS_AUDIO    = 8'd5;
    localparam logic [7:0] MSG_COLOR_RESULT = 8'd7;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_EMPTY     = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_connection;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] msg_type;
        logic [7:0] data_byte;
        logic       last;
    } t_out;

    // One result handed from the parser to the queue
    typedef struct packed {
        logic valid;
        t_out item;
    } t_push;

endpackage

`default_nettype wire

### design/tfd_front.sv
`default_nettype none

module tfd_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire tfd_pkg::t_in                i_item,
    input  wire logic                        i_cfg_we,
    input  wire logic [tfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tfd_pkg::t_push                   o_push
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DEAD    = 2'd2;

    localparam logic [3:0] HDR_TYPE_POS   = 4'd4;
    localparam logic [3:0] HDR_SIZE_POS   = 4'd8;
    localparam logic [3:0] HDR_MAGIC_END  = 4'd4;
    localparam logic [3:0] HDR_LAST_POS   = 4'd11;

    // Configuration
    logic [31:0] r_magic_word;
    logic [11:0] r_command_cap;
    logic [11:0] r_ocr_text_cap;
    logic [11:0] r_color_text_cap;
    logic [15:0] r_audio_cap;

    // Parser state
    logic [1:0]  r_phase,      n_phase;
    logic [3:0]  r_hdr_cnt,    n_hdr_cnt;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [15:0] r_keep_left,  n_keep_left;
    logic [31:0] r_magic,      n_magic;
    logic [7:0]  r_type,       n_type;
    logic [31:0] r_size,       n_size;

    // Effective state after a connection restart
    logic [1:0]  w_phase;
    logic [3:0]  w_hdr_cnt;
    logic [31:0] w_bytes_left;
    logic [15:0] w_keep_left;
    logic [31:0] w_bytes_dec;

    // Kept count for the header being closed
    logic [31:0] w_size_full;
    logic [15:0] w_cap;
    logic        w_known;
    logic        w_texty;
    logic        w_audio;
    logic [15:0] w_keep_min;
    logic [15:0] w_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word     <= tfd_pkg::RST_MAGIC_WORD;
            r_command_cap    <= tfd_pkg::RST_COMMAND_CAP;
            r_ocr_text_cap   <= tfd_pkg::RST_OCR_TEXT_CAP;
            r_color_text_cap <= tfd_pkg::RST_COLOR_TEXT_CAP;
            r_audio_cap      <= tfd_pkg::RST_AUDIO_CAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tfd_pkg::REG_MAGIC_WORD:     r_magic_word     <= i_cfg_data;
                tfd_pkg::REG_COMMAND_CAP:    r_command_cap    <= i_cfg_data[11:0];
                tfd_pkg::REG_OCR_TEXT_CAP:   r_ocr_text_cap   <= i_cfg_data[11:0];
                tfd_pkg::REG_COLOR_TEXT_CAP: r_color_text_cap <= i_cfg_data[11:0];
                tfd_pkg::REG_AUDIO_CAP:      r_audio_cap      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_size_full = {i_item.rx_byte, r_size[31:8]};
        w_known     = 1'b1;
        w_texty     = 1'b1;
        w_audio     = 1'b0;
        case (r_type)
            tfd_pkg::MSG_COMMAND:      w_cap = {4'd0, r_command_cap};
            tfd_pkg::MSG_OCR_RESULT:   w_cap = {4'd0, r_ocr_text_cap};
            tfd_pkg::MSG_COLOR_RESULT: w_cap = {4'd0, r_color_text_cap};
            tfd_pkg::MSG_TTS_AUDIO: begin
                w_cap   = {r_audio_cap[15:1], 1'b0};
                w_texty = 1'b0;
                w_audio = 1'b1;
            end
            default: begin
                w_cap   = 16'd0;
                w_known = 1'b0;
                w_texty = 1'b0;
            end
        endcase
        w_keep_min = (w_size_full < {16'd0, w_cap}) ? w_size_full[15:0] : w_cap;
        // audio keeps whole 16-bit samples only
        w_keep     = w_audio ? {w_keep_min[15:1], 1'b0} : w_keep_min;
    end

    always_comb begin
        w_phase      = r_phase;
        w_hdr_cnt    = r_hdr_cnt;
        w_bytes_left = r_bytes_left;
        w_keep_left  = r_keep_left;
        if (i_item.new_connection) begin
            w_phase      = PH_HEADER;
            w_hdr_cnt    = 4'd0;
            w_bytes_left = 32'd0;
            w_keep_left  = 16'd0;
        end
        w_bytes_dec = w_bytes_left - {31'd0, (w_bytes_left != 32'd0)};

        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_bytes_left = r_bytes_left;
        n_keep_left  = r_keep_left;
        n_magic      = r_magic;
        n_type       = r_type;
        n_size       = r_size;
        o_push       = '0;

        if (i_accept) begin
            n_phase      = w_phase;
            n_hdr_cnt    = w_hdr_cnt;
            n_bytes_left = w_bytes_left;
            n_keep_left  = w_keep_left;
            case (w_phase)
                PH_PAYLOAD: begin
                    if (w_keep_left != 16'd0) begin
                        o_push.valid          = 1'b1;
                        o_push.item.kind      = tfd_pkg::KIND_PAYLOAD;
                        o_push.item.msg_type  = r_type;
                        o_push.item.data_byte = i_item.rx_byte;
                        o_push.item.last      = (w_keep_left == 16'd1);
                        n_keep_left           = w_keep_left - 16'd1;
                    end
                    n_bytes_left = w_bytes_dec;
                    if (w_bytes_dec == 32'd0) begin
                        n_phase     = PH_HEADER;
                        n_hdr_cnt   = 4'd0;
                        n_keep_left = 16'd0;
                    end
                end
                PH_HEADER: begin
                    if (w_hdr_cnt < HDR_MAGIC_END) begin
                        n_magic = {i_item.rx_byte, r_magic[31:8]};
                    end else if (w_hdr_cnt == HDR_TYPE_POS) begin
                        n_type = i_item.rx_byte;
                    end else if (w_hdr_cnt >= HDR_SIZE_POS) begin
                        n_size = w_size_full;
                    end
                    if (w_hdr_cnt != HDR_LAST_POS) begin
                        n_hdr_cnt = w_hdr_cnt + 4'd1;
                    end else begin
                        n_hdr_cnt = 4'd0;
                        if (r_magic != r_magic_word) begin
                            n_phase               = PH_DEAD;
                            n_bytes_left          = 32'd0;
                            n_keep_left           = 16'd0;
                            o_push.valid          = 1'b1;
                            o_push.item.kind      = tfd_pkg::KIND_BAD_MAGIC;
                            o_push.item.msg_type  = r_type;
                            o_push.item.last      = 1'b1;
                        end else begin
                            n_bytes_left = w_size_full;
                            n_keep_left  = w_known ? w_keep : 16'd0;
                            n_phase      = (w_size_full != 32'd0) ? PH_PAYLOAD : PH_HEADER;
                            if (w_texty && (w_keep == 16'd0)) begin
                                o_push.valid         = 1'b1;
                                o_push.item.kind     = tfd_pkg::KIND_EMPTY;
                                o_push.item.msg_type = r_type;
                                o_push.item.last     = 1'b1;
                            end
                        end
                    end
                end
                default: ;  // dead: drop the byte
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_cnt    <= 4'd0;
            r_bytes_left <= 32'd0;
            r_keep_left  <= 16'd0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_bytes_left <= n_bytes_left;
            r_keep_left  <= n_keep_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_magic <= n_magic;
        r_type  <= n_type;
        r_size  <= n_size;
    end

endmodule

`default_nettype wire

### design/tfd_queue.sv
`default_nettype none

module tfd_queue #(
    parameter int P_DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tfd_pkg::t_push i_push,
    input  wire logic           i_stall,
    output logic                o_valid,
    output tfd_pkg::t_out       o_data,
    output logic                o_full,
    output logic                o_empty
);

    localparam int ADDR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W  = $clog2(P_DEPTH + 1);

    tfd_pkg::t_out r_mem [P_DEPTH];

    logic [ADDR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ADDR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              r_out_valid, n_out_valid;
    tfd_pkg::t_out     r_out;
    logic              w_load;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    // refill the output register when it is free or being taken
    assign w_load  = !o_empty && (!r_out_valid || !i_stall);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == ADDR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + ADDR_W'(1);
        end
        if (w_load) begin
            n_rd_ptr = (r_rd_ptr == ADDR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + ADDR_W'(1);
        end
        n_count = r_count + CNT_W'(i_push.valid) - CNT_W'(w_load);
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
        if (w_load) begin
            r_out <= r_mem[r_rd_ptr];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

### design/typed_frame_deframer.sv
// Typed frame deframer: splits a received byte stream into typed messages.
// Input channel i_valid / o_stall carries one stream byte per transaction,
// with new_connection marking the first header byte of a fresh connection.
// Output channel o_valid / i_stall carries results: kept payload bytes (last
// marks the final kept byte), empty-message results and bad-magic errors.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user is to write them only while the block is idle, which
// the block itself does not enforce. Unknown indexes are ignored.
// Throughput: one byte per clock while o_stall is low. The parser handles
// each byte in the cycle it is taken and pushes any result into a queue of
// P_QUEUE_DEPTH entries. The queue is written at the edge that takes the
// byte; the output register loads from it when it is free or being taken.
// When the receiver stalls, the output transaction holds and results collect
// in the queue; o_stall rises once the queue is full and drops as it drains.
// Reset (synchronous, active low) restores the register defaults, empties
// the queue and the output register, and returns the parser to header byte 0.
`default_nettype none

`include "assert_macros.svh"

module typed_frame_deframer #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire tfd_pkg::t_in                   i_data,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output tfd_pkg::t_out                       o_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [tfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic           w_accept;
    logic           w_full;
    logic           w_empty;
    tfd_pkg::t_push w_push;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    tfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_push)
    );

    tfd_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    `TFD_ASSERT(a_push_not_full, i_clk, i_rst_n, w_push.valid |-> !w_full, "push into full queue")

    `TFD_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n, !o_valid && !w_empty, o_valid, "queued result not presented")

    `TFD_ASSERT(a_kind_legal, i_clk, i_rst_n, o_valid |-> (o_data.kind == tfd_pkg::KIND_PAYLOAD || o_data.kind == tfd_pkg::KIND_EMPTY || o_data.kind == tfd_pkg::KIND_BAD_MAGIC), "illegal result kind")

    `TFD_ASSERT(a_status_last, i_clk, i_rst_n, (o_valid && o_data.kind != tfd_pkg::KIND_PAYLOAD) |-> (o_data.last && o_data.data_byte == 8'd0), "status result not last or carries data")

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef enum logic [1:0] {PS_HEADER, PS_PAYLOAD, PS_DEAD} t_parse_phase;

    // One stimulus byte, optionally with its expected transaction typed in
    typedef struct packed {
        logic [7:0]    rx_byte;
        logic          new_conn;
        logic          fixed;
        logic          want;
        tfd_pkg::t_out res;
    } t_dir_row;

    localparam logic [20:0] BY_MODEL  = '0;
    localparam logic [20:0] NO_RESULT = {1'b1, 1'b0, 19'd0};

    t_dir_row dir_rows [25] = '{
        // header with an all-zero magic, type and size all ones
        {8'h00, 1'b1, BY_MODEL},
        {8'h00, 1'b0, BY_MODEL},
        {8'h00, 1'b0, BY_MODEL},
        {8'h00, 1'b0, BY_MODEL},
        {8'hFF, 1'b0, BY_MODEL},
        {8'hFF, 1'b0, BY_MODEL},
        {8'hFF, 1'b0, BY_MODEL},
        {8'hFF, 1'b0, BY_MODEL},
        {8'hFF, 1'b0, BY_MODEL},
        {8'hFF, 1'b0, BY_MODEL},
        {8'hFF, 1'b0, BY_MODEL},
        {8'hFF, 1'b0, 1'b1, 1'b1, tfd_pkg::KIND_BAD_MAGIC, 8'hFF, 8'h00, 1'b1},
        // dead until the next connection
        {8'h5A, 1'b0, NO_RESULT},
        // fresh connection, empty command message
        {8'h53, 1'b1, BY_MODEL},
        {8'h45, 1'b0, BY_MODEL},
        {8'h4E, 1'b0, BY_MODEL},
        {8'h31, 1'b0, BY_MODEL},
        {8'h04, 1'b0, BY_MODEL},
        {8'h00, 1'b0, BY_MODEL},
        {8'h00, 1'b0, BY_MODEL},
        {8'h00, 1'b0, BY_MODEL},
        {8'h00, 1'b0, BY_MODEL},
        {8'h00, 1'b0, BY_MODEL},
        {8'h00, 1'b0, BY_MODEL},
        {8'h00, 1'b0, 1'b1, 1'b1, tfd_pkg::KIND_EMPTY, tfd_pkg::MSG_COMMAND, 8'h00, 1'b1}
    };

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    tfd_pkg::t_in                   i_data = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    tfd_pkg::t_out                  o_data;
    logic                           i_cfg_we = 1'b0;
    logic [tfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [tfd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Register copies
    logic [31:0] cfg_magic     = tfd_pkg::RST_MAGIC_WORD;
    logic [11:0] cfg_cmd_cap   = tfd_pkg::RST_COMMAND_CAP;
    logic [11:0] cfg_ocr_cap   = tfd_pkg::RST_OCR_TEXT_CAP;
    logic [11:0] cfg_color_cap = tfd_pkg::RST_COLOR_TEXT_CAP;
    logic [15:0] cfg_audio_cap = tfd_pkg::RST_AUDIO_CAP;

    // Parser state
    t_parse_phase pz_phase   = PS_HEADER;
    logic [3:0]   pz_hdr_cnt = '0;
    logic [31:0]  pz_magic   = '0;
    logic [7:0]   pz_type    = '0;
    logic [31:0]  pz_size    = '0;
    logic [31:0]  pz_remain  = '0;
    logic [31:0]  pz_keep    = '0;

    tfd_pkg::t_out results_due [$];
    tfd_pkg::t_out due_res;
    int   n_err = 0;
    int   n_items = 0;
    int   gap_next = 0;
    int   out_hold = 0;
    int   stall_pick;
    logic valid_hi = 1'b0;
    logic need_nc = 1'b1;
    logic quiet = 1'b0;

    typed_frame_deframer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] clip(input logic [31:0] a, input logic [31:0] b);
        return (a < b) ? a : b;
    endfunction

    // Advance the parser by one byte; return 1 when the byte yields a result
    function automatic logic parse_byte(input tfd_pkg::t_in x, output tfd_pkg::t_out res);
        logic [31:0] keep;
        logic        known;
        logic        texty;
        logic        hit;
        res = '0;
        hit = 1'b0;
        if (x.new_connection) begin
            pz_phase = PS_HEADER;
            pz_hdr_cnt = '0;
            pz_remain = '0;
            pz_keep = '0;
        end
        case (pz_phase)
            PS_PAYLOAD: begin
                if (pz_keep != 0) begin
                    res.kind = tfd_pkg::KIND_PAYLOAD;
                    res.msg_type = pz_type;
                    res.data_byte = x.rx_byte;
                    res.last = (pz_keep == 1);
                    hit = 1'b1;
                    pz_keep = pz_keep - 32'd1;
                end
                if (pz_remain != 0) pz_remain = pz_remain - 32'd1;
                if (pz_remain == 0) begin
                    pz_phase = PS_HEADER;
                    pz_hdr_cnt = '0;
                    pz_keep = '0;
                end
            end
            PS_HEADER: begin
                if (pz_hdr_cnt < 4) pz_magic = {x.rx_byte, pz_magic[31:8]};
                else if (pz_hdr_cnt == 4) pz_type = x.rx_byte;
                else if (pz_hdr_cnt >= 8) pz_size = {x.rx_byte, pz_size[31:8]};
                if (pz_hdr_cnt < 11) begin
                    pz_hdr_cnt = pz_hdr_cnt + 4'd1;
                end else begin
                    pz_hdr_cnt = '0;
                    if (pz_magic != cfg_magic) begin
                        pz_phase = PS_DEAD;
                        pz_remain = '0;
                        pz_keep = '0;
                        res.kind = tfd_pkg::KIND_BAD_MAGIC;
                        res.msg_type = pz_type;
                        res.last = 1'b1;
                        hit = 1'b1;
                    end else begin
                        known = 1'b1;
                        texty = 1'b1;
                        keep = '0;
                        case (pz_type)
                            tfd_pkg::MSG_COMMAND:
                                keep = clip(pz_size, {20'd0, cfg_cmd_cap});
                            tfd_pkg::MSG_OCR_RESULT:
                                keep = clip(pz_size, {20'd0, cfg_ocr_cap});
                            tfd_pkg::MSG_COLOR_RESULT:
                                keep = clip(pz_size, {20'd0, cfg_color_cap});
                            tfd_pkg::MSG_TTS_AUDIO: begin
                                // whole 16-bit samples only
                                keep = clip(pz_size, {16'd0, cfg_audio_cap[15:1], 1'b0});
                                keep[0] = 1'b0;
                                texty = 1'b0;
                            end
                            default: begin
                                known = 1'b0;
                                texty = 1'b0;
                            end
                        endcase
                        pz_remain = pz_size;
                        pz_keep = known ? keep : '0;
                        pz_phase = (pz_remain != 0) ? PS_PAYLOAD : PS_HEADER;
                        if (texty && keep == 0) begin
                            res.kind = tfd_pkg::KIND_EMPTY;
                            res.msg_type = pz_type;
                            res.last = 1'b1;
                            hit = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    task automatic send_byte(input tfd_pkg::t_in x, input logic fixed, input logic want,
                             input tfd_pkg::t_out typed);
        tfd_pkg::t_out res;
        logic got;
        int   pick;
        if (gap_next > 0) repeat (gap_next) @(posedge i_clk);
        if (!valid_hi) begin
            i_valid <= 1'b1;
            valid_hi = 1'b1;
        end
        i_data <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!(pz_phase == PS_DEAD && !x.new_connection)) n_items++;
        got = parse_byte(x, res);
        if (fixed ? want : got) results_due.push_back(fixed ? typed : res);
        gap_next = 0;
        if (!quiet) begin
            pick = $urandom_range(0, 99);
            if (pick >= 95) gap_next = $urandom_range(10, 30);
            else if (pick >= 70) gap_next = $urandom_range(1, 3);
        end
        if (gap_next > 0) begin
            i_valid <= 1'b0;
            valid_hi = 1'b0;
        end
    endtask

    task automatic send_frame(input logic [31:0] magic, input logic [7:0] mtype,
                              input logic [31:0] size, input int nhdr, input int npay);
        logic [7:0]   hdr [12];
        tfd_pkg::t_in x;
        logic         first_nc;
        for (int i = 0; i < 4; i++) begin
            hdr[i] = magic[8*i +: 8];
            hdr[8+i] = size[8*i +: 8];
        end
        hdr[4] = mtype;
        for (int i = 5; i < 8; i++) hdr[i] = 8'($urandom_range(0, 255));
        first_nc = need_nc || ($urandom_range(0, 3) == 0);
        // a cut-short or rejected frame forces a new connection next
        need_nc = (nhdr < 12) || (32'(npay) < size) || (magic != cfg_magic);
        for (int i = 0; i < nhdr; i++) begin
            x.rx_byte = hdr[i];
            x.new_connection = (i == 0) ? first_nc : 1'b0;
            send_byte(x, 1'b0, 1'b0, '0);
        end
        for (int i = 0; i < npay; i++) begin
            x.rx_byte = 8'($urandom_range(0, 255));
            x.new_connection = 1'b0;
            send_byte(x, 1'b0, 1'b0, '0);
        end
    endtask

    task automatic random_msg();
        logic [31:0] magic;
        logic [31:0] size;
        logic [31:0] cap;
        logic [7:0]  mtype;
        int          nhdr;
        int          npay;
        int          pick;
        magic = cfg_magic;
        if ($urandom_range(0, 99) < 8) begin
            magic = $urandom();
            if (magic == cfg_magic) magic = ~magic;
        end
        case ($urandom_range(0, 4))
            0:       mtype = tfd_pkg::MSG_OCR_RESULT;
            1:       mtype = tfd_pkg::MSG_COMMAND;
            2:       mtype = tfd_pkg::MSG_TTS_AUDIO;
            3:       mtype = tfd_pkg::MSG_COLOR_RESULT;
            default: mtype = 8'($urandom_range(0, 255));
        endcase
        case (mtype)
            tfd_pkg::MSG_OCR_RESULT:   cap = {20'd0, cfg_ocr_cap};
            tfd_pkg::MSG_COMMAND:      cap = {20'd0, cfg_cmd_cap};
            tfd_pkg::MSG_TTS_AUDIO:    cap = {16'd0, cfg_audio_cap};
            tfd_pkg::MSG_COLOR_RESULT: cap = {20'd0, cfg_color_cap};
            default:                   cap = 32'd8;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 55) size = $urandom_range(0, 24);
        else if (pick < 80) begin
            // land around the cap when it is small enough to reach cheaply
            if (cap > 200) size = $urandom_range(0, 64);
            else if (cap < 2) size = $urandom_range(0, 4);
            else size = cap - 2 + $urandom_range(0, 4);
        end else if (pick < 93) size = $urandom_range(25, 300);
        else size = $urandom();
        nhdr = 12;
        pick = $urandom_range(0, 99);
        if (magic != cfg_magic) npay = $urandom_range(0, 4);
        else if (size > 300 || pick < 6) npay = $urandom_range(0, (size < 20) ? size : 20);
        else if (pick < 10) begin
            nhdr = $urandom_range(1, 11);
            npay = 0;
        end else npay = size;
        send_frame(magic, mtype, size, nhdr, npay);
    endtask

    task automatic fill(input int n);
        int stop_at;
        stop_at = n_items + n;
        while (n_items < stop_at) random_msg();
    endtask

    // Hold off the sender until every expected transaction has come out
    task automatic settle();
        if (valid_hi) begin
            i_valid <= 1'b0;
            valid_hi = 1'b0;
        end
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [tfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tfd_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] magic, input logic [11:0] cmd_cap,
                             input logic [11:0] ocr_cap, input logic [11:0] color_cap,
                             input logic [15:0] audio_cap);
        cfg_write(tfd_pkg::REG_MAGIC_WORD, magic);
        cfg_write(tfd_pkg::REG_COMMAND_CAP, {20'd0, cmd_cap});
        cfg_write(tfd_pkg::REG_OCR_TEXT_CAP, {20'd0, ocr_cap});
        cfg_write(tfd_pkg::REG_COLOR_TEXT_CAP, {20'd0, color_cap});
        cfg_write(tfd_pkg::REG_AUDIO_CAP, {16'd0, audio_cap});
        i_cfg_we <= 1'b0;
        cfg_magic = magic;
        cfg_cmd_cap = cmd_cap;
        cfg_ocr_cap = ocr_cap;
        cfg_color_cap = color_cap;
        cfg_audio_cap = audio_cap;
    endtask

    // Receiver: random stall runs, mostly short, a few long
    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
            out_hold <= 0;
        end else if (out_hold != 0) begin
            out_hold <= out_hold - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50) begin
                i_stall <= 1'b0;
                out_hold <= $urandom_range(0, 30);
            end else if (stall_pick < 95) begin
                i_stall <= 1'b1;
                out_hold <= $urandom_range(0, 3);
            end else begin
                i_stall <= 1'b1;
                out_hold <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $error("unexpected transaction: kind %0d msg_type %0d data_byte %0d last %0d",
                       o_data.kind, o_data.msg_type, o_data.data_byte, o_data.last);
                n_err++;
            end else begin
                due_res = results_due.pop_front();
                if (o_data.kind !== due_res.kind) begin
                    $error("kind: expected %0d, got %0d", due_res.kind, o_data.kind);
                    n_err++;
                end
                if (o_data.msg_type !== due_res.msg_type) begin
                    $error("msg_type: expected %0d, got %0d", due_res.msg_type,
                           o_data.msg_type);
                    n_err++;
                end
                if (o_data.data_byte !== due_res.data_byte) begin
                    $error("data_byte: expected %0d, got %0d", due_res.data_byte,
                           o_data.data_byte);
                    n_err++;
                end
                if (o_data.last !== due_res.last) begin
                    $error("last: expected %0d, got %0d", due_res.last, o_data.last);
                    n_err++;
                end
            end
        end
    end

    initial begin
        tfd_pkg::t_in x;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            x.rx_byte = dir_rows[k].rx_byte;
            x.new_connection = dir_rows[k].new_conn;
            send_byte(x, dir_rows[k].fixed, dir_rows[k].want, dir_rows[k].res);
        end
        fill(220);

        settle();
        load_regs($urandom(), 12'd0, 12'd1, 12'd4095, 16'd0);
        fill(220);

        // widest command and audio caps, with one long command cut short
        settle();
        load_regs(32'h0000_0000, 12'd4095, 12'd0, 12'd1, 16'd65534);
        send_frame(cfg_magic, tfd_pkg::MSG_COMMAND, 32'd4100, 12, 48);
        fill(220);

        settle();
        load_regs(32'hFFFF_FFFF, 12'($urandom_range(0, 40)), 12'($urandom_range(0, 40)),
                  12'($urandom_range(0, 40)), 16'($urandom_range(0, 20) * 2 + 1));
        fill(220);

        // no idling on either side
        settle();
        quiet = 1'b1;
        load_regs($urandom(), 12'($urandom_range(0, 40)), 12'($urandom_range(0, 40)),
                  12'($urandom_range(0, 40)), 16'($urandom_range(0, 41)));
        fill(220);
        settle();
        quiet = 1'b0;

        load_regs(tfd_pkg::RST_MAGIC_WORD, tfd_pkg::RST_COMMAND_CAP,
                  tfd_pkg::RST_OCR_TEXT_CAP, tfd_pkg::RST_COLOR_TEXT_CAP,
                  tfd_pkg::RST_AUDIO_CAP);
        fill(220);

        settle();
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/tfd_pkg.sv
design/tfd_front.sv
design/tfd_queue.sv
design/typed_frame_deframer.sv
dv/tb.sv
